[rtl/sic_pkg.sv]
// shared types, register indexes and pipeline latencies for the sensor compensation block
package sic_pkg;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } req_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic               pressure_valid;
    logic [16:0]        humidity;
  } res_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic [7:0]         h1;
    logic signed [15:0] h2;
    logic [7:0]         h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } cal_t;

  localparam logic [2:0] REG_TEMP_CAL       = 3'd0;
  localparam logic [2:0] REG_PRESS_CAL_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_CAL_HIGH = 3'd2;
  localparam logic [2:0] REG_MIXED_CAL      = 3'd3;
  localparam logic [2:0] REG_HUM_CAL_MID    = 3'd4;

  localparam int DIV_STEPS = 64;
  // six stages before the divider, five after it
  localparam int PRESS_LAT = 6 + DIV_STEPS + 5;
  localparam int HUM_LAT   = 7;
  // three temperature stages, pressure path, output register
  localparam int TOTAL_LAT = 3 + PRESS_LAT + 1;

  localparam logic [16:0] HUM_MAX = 17'd102400;

endpackage

[rtl/sic_press.sv]
// pressure compensation pipeline with a one-bit-per-stage 64-bit divider
module sic_press (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_vld,
  input  logic signed [31:0]  tf,
  input  logic [19:0]         raw_press,
  input  sic_pkg::cal_t       cal,
  output logic                out_vld,
  output logic [31:0]         pressure,
  output logic                pressure_valid
);
  import sic_pkg::*;

  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign p1 = $signed({48'b0, cal.p1});
  assign p2 = 64'(cal.p2);
  assign p3 = 64'(cal.p3);
  assign p4 = 64'(cal.p4);
  assign p5 = 64'(cal.p5);
  assign p6 = 64'(cal.p6);
  assign p7 = 64'(cal.p7);
  assign p8 = 64'(cal.p8);
  assign p9 = 64'(cal.p9);

  // stage a: squares and first products of the temperature offset
  logic signed [63:0] a_in;
  logic               va;
  logic signed [63:0] aa, ap5, ap2;
  logic [19:0]        pr_a;
  assign a_in = 64'(tf) - 64'sd128000;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= in_vld;
    end
    aa   <= a_in * a_in;
    ap5  <= a_in * p5;
    ap2  <= a_in * p2;
    pr_a <= raw_press;
  end

  // stage b
  logic               vb;
  logic signed [63:0] b1, a3, b2, a2;
  logic [19:0]        pr_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
    b1   <= aa * p6;
    a3   <= aa * p3;
    b2   <= ap5 <<< 17;
    a2   <= ap2 <<< 12;
    pr_b <= pr_a;
  end

  // stage c
  logic               vc;
  logic signed [63:0] bsum, a1;
  logic [19:0]        pr_c;
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
    bsum <= b1 + b2 + (p4 <<< 35);
    a1   <= (a3 >>> 8) + a2;
    pr_c <= pr_b;
  end

  // stage d
  logic               vd;
  logic signed [63:0] am, pn, adp;
  assign adp = $signed({44'b0, pr_c});
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vc;
    end
    am <= ((64'sd1 <<< 47) + a1) * p1;
    pn <= ((64'sd1048576 - adp) <<< 31) - bsum;
  end

  // stage e: divisor and dividend
  logic               ve;
  logic signed [63:0] den, num;
  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else begin
      ve <= vd;
    end
    den <= am >>> 33;
    num <= pn * 64'sd3125;
  end

  // divider stage array, entry 0 holds magnitudes and signs
  logic [63:0] dv_rem  [0:DIV_STEPS];
  logic [63:0] dv_nq   [0:DIV_STEPS];
  logic [63:0] dv_ud   [0:DIV_STEPS];
  logic        dv_vld  [0:DIV_STEPS];
  logic        dv_zero [0:DIV_STEPS];
  logic        dv_qneg [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= ve;
    end
    dv_rem[0]  <= '0;
    dv_nq[0]   <= num[63] ? 64'(-num) : num;
    dv_ud[0]   <= den[63] ? 64'(-den) : den;
    dv_zero[0] <= (den == 64'sd0);
    dv_qneg[0] <= num[63] ^ den[63];
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [64:0] r2, df;
    assign r2 = {dv_rem[k], dv_nq[k][63]};
    assign df = r2 - {1'b0, dv_ud[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else begin
        dv_vld[k+1] <= dv_vld[k];
      end
      dv_rem[k+1]  <= df[64] ? r2[63:0] : df[63:0];
      dv_nq[k+1]   <= {dv_nq[k][62:0], ~df[64]};
      dv_ud[k+1]   <= dv_ud[k];
      dv_zero[k+1] <= dv_zero[k];
      dv_qneg[k+1] <= dv_qneg[k];
    end
  end

  // stage g: signed quotient
  logic               vg, zg;
  logic signed [63:0] pq;
  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else begin
      vg <= dv_vld[DIV_STEPS];
    end
    pq <= dv_qneg[DIV_STEPS] ? $signed(64'(-dv_nq[DIV_STEPS])) : $signed(dv_nq[DIV_STEPS]);
    zg <= dv_zero[DIV_STEPS];
  end

  // stage h
  logic               vh, zh;
  logic signed [63:0] ph, q13, c1, e1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vh <= 1'b0;
    end else begin
      vh <= vg;
    end
    q13 <= pq >>> 13;
    c1  <= p9 * (pq >>> 13);
    e1  <= p8 * pq;
    ph  <= pq;
    zh  <= zg;
  end

  // stage i: low 64 bits of c1 * q13 as three 32-bit partial products
  logic               vi, zi;
  logic signed [63:0] pi_q, ee;
  logic [31:0]        c1_lo, c1_hi, q_lo, q_hi;
  logic [63:0]        c2_ll;
  logic [31:0]        c2_lh, c2_hl;
  assign c1_lo = c1[31:0];
  assign c1_hi = c1[63:32];
  assign q_lo  = q13[31:0];
  assign q_hi  = q13[63:32];
  always_ff @(posedge clk) begin
    if (rst) begin
      vi <= 1'b0;
    end else begin
      vi <= vh;
    end
    c2_ll <= {32'b0, c1_lo} * {32'b0, q_lo};
    c2_lh <= c1_lo * q_hi;
    c2_hl <= c1_hi * q_lo;
    ee    <= e1 >>> 19;
    pi_q  <= ph;
    zi    <= zh;
  end

  // stage j
  logic               vj, zj;
  logic signed [63:0] psum;
  logic [63:0]        c2;
  assign c2 = c2_ll + {c2_lh + c2_hl, 32'b0};
  always_ff @(posedge clk) begin
    if (rst) begin
      vj <= 1'b0;
    end else begin
      vj <= vi;
    end
    psum <= pi_q + ($signed(c2) >>> 25) + ee;
    zj   <= zi;
  end

  // stage k: final scale, zero divisor forces zero
  logic signed [63:0] pfin;
  assign pfin = (psum >>> 8) + (p7 <<< 4);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vj;
    end
    pressure       <= zj ? 32'd0 : pfin[31:0];
    pressure_valid <= ~zj;
  end

endmodule

[rtl/sic_hum.sv]
// humidity compensation pipeline, 32-bit wrapping arithmetic
module sic_hum (
  input  logic               clk,
  input  logic signed [31:0] tf,
  input  logic [15:0]        raw_hum,
  input  sic_pkg::cal_t      cal,
  output logic [16:0]        humidity
);
  import sic_pkg::*;

  logic signed [31:0] h1, h2, h3, h4, h5, h6, v, adh;
  assign h1  = $signed({24'b0, cal.h1});
  assign h3  = $signed({24'b0, cal.h3});
  assign h2  = 32'(cal.h2);
  assign h4  = 32'(cal.h4);
  assign h5  = 32'(cal.h5);
  assign h6  = 32'(cal.h6);
  assign v   = tf - 32'sd76800;
  assign adh = $signed({16'b0, raw_hum});

  logic signed [31:0] x0, y0, z0, x1, yz, x2, w1, vv, vv5, ss, vv6, tt, r;

  always_ff @(posedge clk) begin
    x0 <= (adh <<< 14) - (h4 <<< 20) - h5 * v;
    y0 <= v * h6;
    z0 <= v * h3;
    // stage 2
    x1 <= (x0 + 32'sd16384) >>> 15;
    yz <= (y0 >>> 10) * ((z0 >>> 11) + 32'sd32768);
    // stage 3
    x2 <= x1;
    w1 <= ((yz >>> 10) + 32'sd2097152) * h2;
    // stage 4
    vv <= x2 * ((w1 + 32'sd8192) >>> 14);
    // stage 5
    vv5 <= vv;
    ss  <= (vv >>> 15) * (vv >>> 15);
    // stage 6
    vv6 <= vv5;
    tt  <= (ss >>> 7) * h1;
  end

  assign r = vv6 - (tt >>> 4);

  // stage 7: clamp to 0..100 %RH
  always_ff @(posedge clk) begin
    if (r[31]) begin
      humidity <= '0;
    end else if (r > 32'sd419430400) begin
      humidity <= HUM_MAX;
    end else begin
      humidity <= r[28:12];
    end
  end

endmodule

[rtl/sensor_integer_compensation_top.sv]
// top level of the integer sensor compensation pipeline
// usage:
//   a request is taken on a rising edge with start high and busy low; req
//   carries the raw temperature, pressure and humidity codes
//   calibration is written through cfg_we, cfg_index and cfg_data, one
//   register per cycle, while no request is in flight
//   each request gives exactly one result: done is high for one cycle and
//   res holds temperature, pressure, pressure_valid and humidity
// timing:
//   a new request can be taken every cycle outside reset; throughput is one per cycle
//   the latency is set mostly by the 64-stage restoring divider of the
//   pressure path, one quotient bit per stage
// reset:
//   rst is synchronous; it clears every stage valid bit and the calibration
//   registers, so nothing in flight survives; busy is high during reset
// back pressure:
//   the receiver cannot stall, results are shown once and never held
module sensor_integer_compensation_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sic_pkg::req_t req,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  output logic          done,
  output sic_pkg::res_t res
);
  import sic_pkg::*;

  // calibration registers
  logic [47:0] temp_cal;
  logic [63:0] press_cal_low;
  logic [63:0] press_cal_high;
  logic [55:0] mixed_cal;
  logic [23:0] hum_cal_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal       <= '0;
      press_cal_low  <= '0;
      press_cal_high <= '0;
      mixed_cal      <= '0;
      hum_cal_mid    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_CAL:       temp_cal       <= cfg_data[47:0];
        REG_PRESS_CAL_LOW:  press_cal_low  <= cfg_data;
        REG_PRESS_CAL_HIGH: press_cal_high <= cfg_data;
        REG_MIXED_CAL:      mixed_cal      <= cfg_data[55:0];
        REG_HUM_CAL_MID:    hum_cal_mid    <= cfg_data[23:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // unpack calibration words into named coefficients
  cal_t cal;
  assign cal.t1 = temp_cal[15:0];
  assign cal.t2 = temp_cal[31:16];
  assign cal.t3 = temp_cal[47:32];
  assign cal.p1 = press_cal_low[15:0];
  assign cal.p2 = press_cal_low[31:16];
  assign cal.p3 = press_cal_low[47:32];
  assign cal.p4 = press_cal_low[63:48];
  assign cal.p5 = press_cal_high[15:0];
  assign cal.p6 = press_cal_high[31:16];
  assign cal.p7 = press_cal_high[47:32];
  assign cal.p8 = press_cal_high[63:48];
  assign cal.p9 = mixed_cal[15:0];
  assign cal.h1 = mixed_cal[23:16];
  assign cal.h2 = mixed_cal[39:24];
  assign cal.h3 = mixed_cal[47:40];
  assign cal.h6 = mixed_cal[55:48];
  assign cal.h4 = hum_cal_mid[11:0];
  assign cal.h5 = hum_cal_mid[23:12];

  // never stalls, only refuses requests while in reset
  assign busy = rst;

  logic accept;
  assign accept = start & ~busy;

  // temperature stage 1: the two first-level products
  logic signed [31:0] adt, t1e, t2e, t3e, x1, dlt;
  assign adt = $signed({12'b0, req.raw_temp});
  assign t1e = $signed({16'b0, cal.t1});
  assign t2e = 32'(cal.t2);
  assign t3e = 32'(cal.t3);
  assign x1  = (adt >>> 3) - (t1e <<< 1);
  assign dlt = (adt >>> 4) - t1e;

  logic               s1_vld, s2_vld, s3_vld;
  logic signed [31:0] s1_m1, s1_dd, s2_v1, s2_m2, s3_tf;
  logic [19:0]        s1_press, s2_press, s3_press;
  logic [15:0]        s1_hum, s2_hum, s3_hum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
    s1_m1    <= x1 * t2e;
    s1_dd    <= dlt * dlt;
    s1_press <= req.raw_press;
    s1_hum   <= req.raw_hum;
    // stage 2: quadratic term
    s2_v1    <= s1_m1 >>> 11;
    s2_m2    <= (s1_dd >>> 12) * t3e;
    s2_press <= s1_press;
    s2_hum   <= s1_hum;
    // stage 3: fine temperature
    s3_tf    <= s2_v1 + (s2_m2 >>> 14);
    s3_press <= s2_press;
    s3_hum   <= s2_hum;
  end

  // pressure and humidity both start from the fine temperature
  logic        pr_vld, pr_valid;
  logic [31:0] pr_value;
  logic [16:0] hum_value;

  sic_press u_press (
    .clk            (clk),
    .rst            (rst),
    .in_vld         (s3_vld),
    .tf             (s3_tf),
    .raw_press      (s3_press),
    .cal            (cal),
    .out_vld        (pr_vld),
    .pressure       (pr_value),
    .pressure_valid (pr_valid)
  );

  sic_hum u_hum (
    .clk      (clk),
    .tf       (s3_tf),
    .raw_hum  (s3_hum),
    .cal      (cal),
    .humidity (hum_value)
  );

  // temperature output computed once, then delayed to line up with pressure
  logic signed [31:0] temp_line [0:PRESS_LAT-1];
  logic [16:0]        hum_line  [0:PRESS_LAT-HUM_LAT-1];

  always_ff @(posedge clk) begin
    temp_line[0] <= (s3_tf * 32'sd5 + 32'sd128) >>> 8;
    for (int i = 1; i < PRESS_LAT; i++) begin
      temp_line[i] <= temp_line[i-1];
    end
    hum_line[0] <= hum_value;
    for (int i = 1; i < PRESS_LAT - HUM_LAT; i++) begin
      hum_line[i] <= hum_line[i-1];
    end
  end

  // output register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pr_vld;
    end
    res.temperature    <= temp_line[PRESS_LAT-1];
    res.pressure       <= pr_value;
    res.pressure_valid <= pr_valid;
    res.humidity       <= hum_line[PRESS_LAT-HUM_LAT-1];
  end

endmodule

[rtl/sic_check.sv]
// port-level checks for the compensation top level, bound to it
module sic_check (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input sic_pkg::res_t res
);
  import sic_pkg::*;

  // every result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without matching request");

  // a refused divide reports zero pressure
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (done && !res.pressure_valid) |-> (res.pressure == 32'd0))
    else $error("invalid pressure not zero");

  // humidity stays clamped
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.humidity <= HUM_MAX))
    else $error("humidity above full scale");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

endmodule

bind sensor_integer_compensation_top sic_check u_sic_check (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);

[tb/testbench.sv]
// testbench for the integer sensor compensation pipeline: random and directed requests
`timescale 1ns / 1ps
module testbench;
  import sic_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        done;
  res_t        res;

  sensor_integer_compensation_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .res(res)
  );

  always #6 clk = ~clk;

  // calibration shadow, kept as raw register images
  logic [47:0] cal_temp;
  logic [63:0] cal_press_lo, cal_press_hi;
  logic [55:0] cal_mixed;
  logic [23:0] cal_hum;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   error_count = 0;
  int   request_count = 0;
  int   result_count = 0;
  int   invalid_press_count = 0;
  int   setting_count = 0;
  logic stim_done = 1'b0;

  // signed 64-bit truncating divide with wrap on the single overflow case
  function automatic logic signed [63:0] div_trunc(logic signed [63:0] n,
                                                   logic signed [63:0] d);
    logic [63:0] un, ud, q;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    q = un / ud;
    if (n[63] != d[63]) q = -q;
    return q;
  endfunction

  // fixed-point compensation of one set of raw codes
  function automatic res_t compensate(req_t r);
    res_t o;
    logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] adc_t, adc_h, v1, v2, dt, tf, tmp;
    logic signed [31:0] hv, hx, hy, hz, hw, hs;
    logic signed [63:0] adc_p, a, b, p, c, e;
    t1 = $signed({16'd0, cal_temp[15:0]});
    t2 = $signed(cal_temp[31:16]);
    t3 = $signed(cal_temp[47:32]);
    p1 = $signed({48'd0, cal_press_lo[15:0]});
    p2 = $signed(cal_press_lo[31:16]);
    p3 = $signed(cal_press_lo[47:32]);
    p4 = $signed(cal_press_lo[63:48]);
    p5 = $signed(cal_press_hi[15:0]);
    p6 = $signed(cal_press_hi[31:16]);
    p7 = $signed(cal_press_hi[47:32]);
    p8 = $signed(cal_press_hi[63:48]);
    p9 = $signed(cal_mixed[15:0]);
    h1 = $signed({24'd0, cal_mixed[23:16]});
    h2 = $signed(cal_mixed[39:24]);
    h3 = $signed({24'd0, cal_mixed[47:40]});
    h6 = $signed(cal_mixed[55:48]);
    h4 = $signed(cal_hum[11:0]);
    h5 = $signed(cal_hum[23:12]);
    adc_t = $signed({12'd0, r.raw_temp});
    adc_p = $signed({44'd0, r.raw_press});
    adc_h = $signed({16'd0, r.raw_hum});

    // temperature and fine temperature
    v1 = ((adc_t >>> 3) - (t1 <<< 1)) * t2 >>> 11;
    dt = (adc_t >>> 4) - t1;
    tmp = dt * dt;
    v2 = ((tmp >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    o.temperature = (tf * 5 + 128) >>> 8;

    // pressure, 64-bit path
    a = 64'(tf) - 64'sd128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    if (a == 0) begin
      o.pressure = '0;
      o.pressure_valid = 1'b0;
    end else begin
      p = 64'sd1048576 - adc_p;
      p = div_trunc(((p <<< 31) - b) * 64'sd3125, a);
      c = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      e = (p8 * p) >>> 19;
      p = ((p + c + e) >>> 8) + (p7 <<< 4);
      o.pressure = p[31:0];
      o.pressure_valid = 1'b1;
    end

    // humidity, clamped to 0..100 percent
    hv = tf - 32'sd76800;
    hx = (adc_h <<< 14) - (h4 <<< 20) - h5 * hv;
    hx = (hx + 32'sd16384) >>> 15;
    hy = (hv * h6) >>> 10;
    hz = ((hv * h3) >>> 11) + 32'sd32768;
    hw = ((hy * hz) >>> 10) + 32'sd2097152;
    hw = (hw * h2 + 32'sd8192) >>> 14;
    hv = hx * hw;
    hs = hv >>> 15;
    tmp = hs * hs;
    hv = hv - ((((tmp >>> 7) * h1)) >>> 4);
    if (hv < 0) hv = 0;
    if (hv > 32'sd419430400) hv = 32'sd419430400;
    o.humidity = hv[28:12];
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver: gap drawn per request, start held across back-to-back requests
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // request still waiting
    end else begin
      if (start) begin
        expected_results.push_back(compensate(req));
        request_count++;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        start <= 1'b1;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every done pulse is compared with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 64'(res.pressure), 64'd0);
      end else begin
        res_t want;
        want = expected_results.pop_front();
        result_count++;
        if (!want.pressure_valid) invalid_press_count++;
        if (res.temperature !== want.temperature)
          report("temperature", 64'(res.temperature), 64'(want.temperature));
        if (res.pressure !== want.pressure)
          report("pressure", 64'(res.pressure), 64'(want.pressure));
        if (res.pressure_valid !== want.pressure_valid)
          report("pressure_valid", 64'(res.pressure_valid), 64'(want.pressure_valid));
        if (res.humidity !== want.humidity)
          report("humidity", 64'(res.humidity), 64'(want.humidity));
      end
    end
  end

  // one calibration write, mirrored into the shadow copy
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TEMP_CAL:       cal_temp = val[47:0];
      REG_PRESS_CAL_LOW:  cal_press_lo = val;
      REG_PRESS_CAL_HIGH: cal_press_hi = val;
      REG_MIXED_CAL:      cal_mixed = val[55:0];
      REG_HUM_CAL_MID:    cal_hum = val[23:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [63:0] t, logic [63:0] pl, logic [63:0] ph,
                           logic [63:0] m, logic [63:0] h);
    write_reg(REG_TEMP_CAL, t);
    write_reg(REG_PRESS_CAL_LOW, pl);
    write_reg(REG_PRESS_CAL_HIGH, ph);
    write_reg(REG_MIXED_CAL, m);
    write_reg(REG_HUM_CAL_MID, h);
    setting_count++;
  endtask

  // wait for the pipeline to drain before touching calibration
  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (TOTAL_LAT + 4) @(posedge clk);
  endtask

  function automatic req_t make_req(logic [19:0] t, logic [19:0] p, logic [15:0] h);
    req_t r;
    r.raw_temp = t;
    r.raw_press = p;
    r.raw_hum = h;
    return r;
  endfunction

  // codes near typical readings, with full-range noise mixed in
  function automatic req_t rand_req();
    req_t r;
    if ($urandom_range(0, 3) == 0) begin
      r = make_req(20'($urandom), 20'($urandom), 16'($urandom));
    end else begin
      r = make_req(20'($urandom_range(400000, 600000)),
                   20'($urandom_range(250000, 450000)),
                   16'($urandom_range(20000, 40000)));
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    cal_temp = '0; cal_press_lo = '0; cal_press_hi = '0; cal_mixed = '0; cal_hum = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset calibration: p1 is zero so pressure is invalid
    pending_reqs.push_back(make_req(20'd0, 20'd0, 16'd0));
    pending_reqs.push_back(make_req(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
    drain();

    // typical datasheet-like calibration
    write_all(64'({16'sd50, 16'sd26435, 16'd27504}),
              {16'sd2855, 16'sd3024, -16'sd10685 & 16'hFFFF, 16'd36477},
              {16'sd15500, -16'sd14600 & 16'hFFFF, -16'sd7 & 16'hFFFF, 16'sd140},
              64'({8'sd30, 8'd0, 16'sd359, 8'd75, 16'sd6000}),
              64'({12'sd50, 12'sd320}));
    pending_reqs.push_back(make_req(20'd519888, 20'd415148, 16'd30000));
    pending_reqs.push_back(make_req(20'd0, 20'hFFFFF, 16'd0));
    pending_reqs.push_back(make_req(20'hFFFFF, 20'd0, 16'hFFFF));
    pending_reqs.push_back(make_req(20'h55555, 20'hAAAAA, 16'h5555));
    pending_reqs.push_back(make_req(20'hAAAAA, 20'h55555, 16'hAAAA));
    pending_reqs.push_back(make_req(20'd500000, 20'd300000, 16'd65535));
    pending_reqs.push_back(make_req(20'd500000, 20'd300000, 16'd0));
    drain();

    // extremes: all ones and most negative fields
    write_all(64'hFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
              64'hFFFFFFFFFFFFFF, 64'hFFFFFF);
    for (int i = 0; i < 4; i++) pending_reqs.push_back(rand_req());
    pending_reqs.push_back(make_req(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
    drain();
    write_all(64'h800080007FFF, 64'h800080008000FFFF, 64'h7FFF80007FFF8000,
              64'h80FF8000FF8000, 64'h800800);
    for (int i = 0; i < 4; i++) pending_reqs.push_back(rand_req());
    drain();
    // out-of-range index must be ignored
    write_reg(3'd5, rand64());
    write_reg(3'd7, rand64());
    pending_reqs.push_back(make_req(20'd0, 20'd0, 16'd0));
    drain();

    // random phases, each with fresh calibration
    for (int ph = 0; ph < 8; ph++) begin
      write_all(rand64(), rand64(), rand64(), rand64(), rand64());
      for (int i = 0; i < 50; i++) pending_reqs.push_back(rand_req());
      drain();
    end
    stim_done = 1'b1;
  end

  // end of run and overall time limit
  initial begin
    wait (stim_done);
    $display("requests %0d, results %0d (%0d with invalid pressure), calibration sets %0d",
             request_count, result_count, invalid_press_count, setting_count);
    if (error_count == 0) begin
      $display("sensor_integer_compensation_top verification clean");
    end else begin
      $display("sensor_integer_compensation_top verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("sensor_integer_compensation_top verification failed");
    $finish;
  end

endmodule
